/* hw/rtl/rau_pkg.sv */
// Shared types and constants of the rational arithmetic unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package rau_pkg;

  localparam int OPW   = 32;        // operand numerator width
  localparam int DW    = OPW - 1;   // operand denominator width
  localparam int WW    = 64;        // wide result width
  localparam int KW    = 7;         // shift count of the gcd, up to WW
  localparam int CNTW  = 6;         // division step counter, WW steps

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  typedef enum logic [1:0] {
    MS_T1  = 2'd0,
    MS_T2  = 2'd1,
    MS_DEN = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic     load;       // capture the operands
    logic     mul_en;     // run one product
    mul_sel_t mul_sel;
    logic     comb;       // form magnitude and sign
    logic     gcd_init;
    logic     gcd_step;
    logic     div_load;   // start a division
    logic     div_den;    // dividend is the denominator, else the magnitude
    logic     div_step;
    logic     div_store;  // write the quotient back
    logic     out_fire;   // register the result
  } cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
  } sts_t;

endpackage

/* hw/rtl/rational_arithmetic_unit_core.sv */
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// Usage: drive in_item with two fractions and an operation (add, subtract,
// multiply, divide) and raise start. The item is taken at a rising edge
// where start is high and busy is low; busy then stays high until the item
// has finished. The result appears on out_item for exactly one cycle with
// out_valid high; the receiver must take it then, since it cannot stall.
// The result is reduced to lowest terms with the sign on the numerator and
// a zero result is 0/1. A zero denominator, or division by zero, gives a
// status of one with a 0/0 result.
// Sequence: one item at a time. The three products share one multiplier, one
// per cycle; the gcd is a binary gcd that does one shift or one subtract per
// cycle; then two restoring divisions by the gcd, first of the magnitude and
// then of the denominator, reduce the result. An erroneous item skips the
// products, the gcd and the divisions. Reset, synchronous and active low,
// returns the controller to idle and drops out_valid; no clearing pass is
// needed.
module rational_arithmetic_unit_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rau_pkg::out_item_t out_item
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rau_datapath u_dp (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

  // A result is only shown once the controller is back in idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // An error result is always 0/0.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status) |-> (out_item.res_num == '0 && out_item.res_den == '0))
    else $error("error result not 0/0");

  // A good result always has a positive denominator.
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.status) |-> (out_item.res_den != '0))
    else $error("zero denominator on good result");

  // One result per item: a result is never followed directly by another.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");

endmodule

/* hw/rtl/rau_datapath.sv */
// Datapath of the rational arithmetic unit: shared multiplier, combine stage,
// binary gcd and a restoring divider. Depends on rau_pkg.
module rau_datapath (
  input  logic               clk,
  input  rau_pkg::in_item_t  in_item,
  input  rau_pkg::cmd_t      cmd,
  output rau_pkg::sts_t      sts,
  output rau_pkg::out_item_t out_item
);

  logic [1:0]              act_r;
  logic                    sa_r, sb_r, sr_r, err_r;
  logic [rau_pkg::OPW-1:0] ma_r, mb_r;
  logic [rau_pkg::DW-1:0]  ad_r, bd_r;
  logic [rau_pkg::WW-1:0]  t1_r, t2_r, den_r, mag_r;
  logic [rau_pkg::WW-1:0]  u_r, v_r, dvs_r, rem_r, q_r;
  logic [rau_pkg::KW-1:0]  k_r;
  rau_pkg::out_item_t      out_r;

  logic [rau_pkg::OPW-1:0] a_lo, b_lo, ma_in, mb_in, mop_a, mop_b;
  logic [rau_pkg::DW-1:0]  ad_in, bd_in;
  logic [2*rau_pkg::OPW-1:0] prod;
  logic                    s2;
  logic [rau_pkg::WW:0]    rem_sh;
  logic                    qbit;

  assign a_lo  = in_item.a_num[rau_pkg::OPW-1:0];
  assign b_lo  = in_item.b_num[rau_pkg::OPW-1:0];
  assign ma_in = a_lo[rau_pkg::OPW-1] ? (~a_lo + 1'b1) : a_lo;
  assign mb_in = b_lo[rau_pkg::OPW-1] ? (~b_lo + 1'b1) : b_lo;
  assign ad_in = in_item.a_den[rau_pkg::DW-1:0];
  assign bd_in = in_item.b_den[rau_pkg::DW-1:0];

  // Operand selection for the one shared multiplier.
  always_comb begin
    mop_a = ma_r;
    mop_b = {1'b0, bd_r};
    case (cmd.mul_sel)
      rau_pkg::MS_T1: begin
        mop_a = ma_r;
        mop_b = (act_r == rau_pkg::ACT_MUL) ? mb_r : {1'b0, bd_r};
      end
      rau_pkg::MS_T2: begin
        mop_a = mb_r;
        mop_b = {1'b0, ad_r};
      end
      rau_pkg::MS_DEN: begin
        mop_a = {1'b0, ad_r};
        mop_b = (act_r == rau_pkg::ACT_DIV) ? mb_r : {1'b0, bd_r};
      end
      default: begin
        mop_a = ma_r;
        mop_b = {1'b0, bd_r};
      end
    endcase
  end

  assign prod   = mop_a * mop_b;
  assign s2     = (act_r == rau_pkg::ACT_SUB) ? ~sb_r : sb_r;
  assign rem_sh = {rem_r, q_r[rau_pkg::WW-1]};
  assign qbit   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_item.action;
      sa_r  <= a_lo[rau_pkg::OPW-1];
      sb_r  <= b_lo[rau_pkg::OPW-1];
      ma_r  <= ma_in;
      mb_r  <= mb_in;
      ad_r  <= ad_in;
      bd_r  <= bd_in;
      err_r <= (ad_in == '0) || (bd_in == '0) ||
               ((in_item.action == rau_pkg::ACT_DIV) && (mb_in == '0));
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rau_pkg::MS_T1:  t1_r  <= rau_pkg::WW'(prod);
        rau_pkg::MS_T2:  t2_r  <= rau_pkg::WW'(prod);
        rau_pkg::MS_DEN: den_r <= rau_pkg::WW'(prod);
        default:         den_r <= rau_pkg::WW'(prod);
      endcase
    end
    if (cmd.comb) begin
      if (act_r == rau_pkg::ACT_ADD || act_r == rau_pkg::ACT_SUB) begin
        if (sa_r == s2) begin
          mag_r <= t1_r + t2_r;
          sr_r  <= sa_r && ((t1_r + t2_r) != '0);
        end else if (t1_r >= t2_r) begin
          mag_r <= t1_r - t2_r;
          sr_r  <= sa_r && (t1_r != t2_r);
        end else begin
          mag_r <= t2_r - t1_r;
          sr_r  <= s2;
        end
      end else begin
        mag_r <= t1_r;
        sr_r  <= (sa_r ^ sb_r) && (t1_r != '0);
      end
    end
    // Binary gcd, one shift or one subtract per cycle.
    if (cmd.gcd_init) begin
      u_r <= mag_r;
      v_r <= den_r;
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end
    // Restoring division by the gcd, one quotient bit per cycle.
    if (cmd.div_load) begin
      dvs_r <= (u_r | v_r) << k_r;
      rem_r <= '0;
      q_r   <= cmd.div_den ? den_r : mag_r;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? rau_pkg::WW'(rem_sh - {1'b0, dvs_r}) : rem_sh[rau_pkg::WW-1:0];
      q_r   <= {q_r[rau_pkg::WW-2:0], qbit};
    end
    // A store that comes with the load of the denominator division ends the
    // magnitude division, so its quotient belongs to the magnitude.
    if (cmd.div_store) begin
      if (cmd.div_den && !cmd.div_load) den_r <= q_r;
      else                              mag_r <= q_r;
    end
    if (cmd.out_fire) begin
      if (err_r) begin
        out_r.res_num <= '0;
        out_r.res_den <= '0;
        out_r.status  <= 1'b1;
      end else begin
        out_r.res_num <= sr_r ? (~mag_r + 1'b1) : mag_r;
        out_r.res_den <= den_r[rau_pkg::WW-2:0];
        out_r.status  <= 1'b0;
      end
    end
  end

  assign sts.err      = err_r;
  assign sts.gcd_done = (u_r == '0) || (v_r == '0);
  assign out_item     = out_r;

endmodule

/* hw/rtl/rau_ctrl.sv */
// Controller state machine of the rational arithmetic unit.
// Sequences the datapath through commands; depends on rau_pkg.
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHK   = 10'b0000000010,
    S_MUL1  = 10'b0000000100,
    S_MUL2  = 10'b0000001000,
    S_MUL3  = 10'b0000010000,
    S_COMB  = 10'b0000100000,
    S_GCD   = 10'b0001000000,
    S_DIVM  = 10'b0010000000,
    S_DIVD  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [rau_pkg::CNTW-1:0] cnt_r, cnt_nxt;
  logic                     first_r, first_nxt;
  logic                     ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    first_nxt = 1'b0;
    ov_nxt    = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = sts.err ? S_DONE : S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_T1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_T2;
        state_nxt   = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_DEN;
        state_nxt   = S_COMB;
      end
      S_COMB: begin
        cmd.comb  = 1'b1;
        first_nxt = 1'b1;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (first_r) begin
          cmd.gcd_init = 1'b1;
        end else if (sts.gcd_done) begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIVM;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVM: begin
        if (first_r) begin
          cmd.div_store = 1'b1;
          cmd.div_load  = 1'b1;
          cmd.div_den   = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          first_nxt    = (cnt_r == '1);
        end
      end
      S_DIVD: begin
        cmd.div_den = 1'b1;
        if (first_r) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          first_nxt    = (cnt_r == '1);
        end
      end
      S_DONE: begin
        cmd.out_fire = 1'b1;
        ov_nxt       = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      first_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;

endmodule
